// ===== hdl/rce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_pkg: shared types and constants
// Opcodes, sequencer states, result record and the fixed code-word constants
// used by the byte-renormalizing range encoder.
// ----------------------------------------------------------------------------
package rce_pkg;

	localparam int unsigned CODE_W     = 32;
	localparam int unsigned BYTE_POS   = CODE_W - 9;
	localparam int unsigned DIVISOR_W  = 17;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CODE_W-1:0] TOP_VAL    = 32'h8000_0000;
	localparam logic [CODE_W-1:0] BOTTOM_VAL = 32'h0080_0000;
	localparam logic [CODE_W-1:0] FF_LIMIT   = 32'h7F80_0000;
	localparam logic [CODE_W-1:0] LOW_MASK   = 32'h7FFF_FFFF;
	localparam logic [CODE_W-1:0] FIN_BYTES  = 32'd5;

	// configuration register indexes
	localparam logic CFG_HEADER_BYTE = 1'b0;
	localparam logic CFG_START_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_CODE_TOTAL = 2'd0,
		OP_CODE_SHIFT = 2'd1,
		OP_FINISH     = 2'd2,
		OP_NONE       = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_EMIT_BYTE,
		S_EMIT_RUN,
		S_SHIFT,
		S_DIV_WAIT,
		S_MUL_T,
		S_MUL_R,
		S_UPDATE,
		S_FIN_PREP,
		S_FIN_BYTE,
		S_FIN_C2,
		S_FIN_C1,
		S_FIN_C0,
		S_CLOSE
	} seq_state_t;

	// one result item without its last flag
	typedef struct packed {
		logic [7:0]        out_byte;
		logic [CODE_W-1:0] repeat_res;
		logic [CODE_W-1:0] byte_total;
	} res_t;

	// requests from the sequencer to the output stage
	typedef struct packed {
		logic push;
		logic close;
	} emit_req_t;

endpackage

// ===== hdl/rce_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_div: iterative restoring divider
// Divides the 32-bit range by the 17-bit total frequency, one quotient bit
// per cycle. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module rce_div
	import rce_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CODE_W-1:0]    dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [CODE_W-1:0]    quotient
);

	localparam int unsigned CNT_W = $clog2(CODE_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CODE_W-1:0]    quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIVISOR_W:0]   trial;
	logic                 fits;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[CODE_W-1]};
		fits  = (trial >= {1'b0, dsr_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CODE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in from the bottom
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dsr_q}) : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[CODE_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/rce_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rce_out: result holdback and output register
// Keeps the newest result back by one so that the last result of an item
// can be flagged when the item closes, and drives the output channel.
// ----------------------------------------------------------------------------
module rce_out
	import rce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  emit_req_t         req,
	input  res_t              res,
	output logic              ack,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic [CODE_W-1:0] repeat_res,
	output logic              last,
	output logic [CODE_W-1:0] byte_total
);

	logic hold_v_q;
	res_t hold_q;
	logic out_v_q;
	res_t out_q;
	logic out_last_q;
	logic can;
	logic load_out;

	// request handling
	always_comb begin
		can      = !hold_v_q || !out_v_q || !out_stall;
		load_out = can && hold_v_q && (req.push || req.close);
	end

	assign ack = can;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= load_out || (out_v_q && out_stall);
			if (can && req.push) begin
				hold_v_q <= 1'b1;
			end else if (can && req.close) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (can && req.push) begin
			hold_q <= res;
		end
		if (load_out) begin
			out_q      <= hold_q;
			out_last_q <= req.close;
		end
	end

	assign out_valid  = out_v_q;
	assign out_byte   = out_q.out_byte;
	assign repeat_res = out_q.repeat_res;
	assign last       = out_last_q;
	assign byte_total = out_q.byte_total;

endmodule

// ===== hdl/range_encoder_byte_renorm.sv =====
`timescale 1ns / 1ps
// Timing: a code item holds the input through the renormalization steps (plus any results
// sent), the divider, the two multiplies and the update; a shift item skips the divider.
// Items are taken one at a time: the next is taken only once the sequencer is back in idle.
// Result stalls stretch each item.
// Reset (arst_n, asynchronous): idle, range 0x80000000, low 0, pending 0,
// registers 0; a finish item returns the coder state to the register values.
// ----------------------------------------------------------------------------
// range_encoder_byte_renorm: byte-renormalizing 32-bit range encoder
// Sequencer around a divider and a shared 32x16 multiplier; emits bytes and
// runs of pending bytes with repeat counts, and closes the stream on finish.
// ----------------------------------------------------------------------------
module range_encoder_byte_renorm
	import rce_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [15:0]           sym_freq,
	input  logic [15:0]           cum_freq,
	input  logic [16:0]           total_freq,
	input  logic [4:0]            total_shift,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic [CODE_W-1:0]     repeat_res,
	output logic                  last,
	output logic [CODE_W-1:0]     byte_total
);

	seq_state_t state_q, state_n;

	// configuration registers
	logic [7:0]            header_q;
	logic [CFG_DATA_W-1:0] start_q;

	// coder state
	logic [CODE_W-1:0] low_q;
	logic [CODE_W-1:0] range_q;
	logic [7:0]        delayed_q;
	logic [CODE_W-1:0] pending_q;
	logic [CODE_W-1:0] counter_q;

	// item and work registers
	opcode_t           op_q;
	logic [15:0]       sym_q;
	logic [15:0]       cum_q;
	logic [16:0]       tot_q;
	logic [4:0]        sh_q;
	logic [CODE_W-1:0] bt_q;
	logic              carry_q;
	logic [7:0]        fin_byte_q;
	logic [CODE_W-1:0] r_q;
	logic [CODE_W-1:0] t_q;
	logic [CODE_W-1:0] rs_q;

	// shared pieces
	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [CODE_W-1:0] div_quo;
	logic [15:0]       mul_b;
	logic [CODE_W-1:0] mul_p;
	emit_req_t         ereq;
	res_t              eres;
	logic              eack;
	logic              need_renorm;
	logic              flush_end;
	logic [1:0]        nsteps;
	logic [16:0]       sum17;
	logic              take_sub;
	logic [CODE_W-1:0] range_new;
	logic [9:0]        fin_t;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;

	// arithmetic helpers
	always_comb begin
		need_renorm = (range_q <= BOTTOM_VAL);
		if (range_q > BOTTOM_VAL) begin
			nsteps = 2'd0;
		end else if (range_q > 32'h0000_8000) begin
			nsteps = 2'd1;
		end else if (range_q > 32'h0000_0080) begin
			nsteps = 2'd2;
		end else begin
			nsteps = 2'd3;
		end
		mul_b = (state_q == S_MUL_T) ? cum_q : sym_q;
		mul_p = CODE_W'(r_q * mul_b);
		sum17 = {1'b0, cum_q} + {1'b0, sym_q};
		if (op_q == OP_CODE_TOTAL) begin
			take_sub = !(sum17 < tot_q);
		end else begin
			take_sub = ((sum17 >> sh_q) != '0);
		end
		range_new = take_sub ? (range_q - t_q) : rs_q;
		if (range_new == '0) begin
			range_new = CODE_W'(1);
		end
		fin_t = (low_q[BYTE_POS-1:0] < bt_q[BYTE_POS:1]) ?
			{1'b0, low_q[CODE_W-1:BYTE_POS]} :
			({1'b0, low_q[CODE_W-1:BYTE_POS]} + 10'd1);
	end

	// flush of the delayed byte completes
	always_comb begin
		flush_end = 1'b0;
		if (state_q == S_EMIT_BYTE && eack && pending_q == '0) begin
			flush_end = 1'b1;
		end
		if (state_q == S_EMIT_RUN && eack) begin
			flush_end = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && opcode_t'(opcode) != OP_NONE) begin
					state_n = S_CHECK;
				end
			end
			S_CHECK: begin
				if (need_renorm) begin
					if (low_q < FF_LIMIT || low_q[CODE_W-1]) begin
						state_n = S_EMIT_BYTE;
					end else begin
						state_n = S_SHIFT;
					end
				end else begin
					case (op_q)
						OP_CODE_TOTAL: state_n = S_DIV_WAIT;
						OP_CODE_SHIFT: state_n = S_MUL_T;
						default:       state_n = S_FIN_PREP;
					endcase
				end
			end
			S_EMIT_BYTE: begin
				if (eack) begin
					state_n = (pending_q != '0) ? S_EMIT_RUN :
						((op_q == OP_FINISH && !need_renorm) ? S_FIN_BYTE : S_SHIFT);
				end
			end
			S_EMIT_RUN: begin
				if (eack) begin
					state_n = (op_q == OP_FINISH && !need_renorm) ? S_FIN_BYTE : S_SHIFT;
				end
			end
			S_SHIFT:    state_n = S_CHECK;
			S_DIV_WAIT: begin
				if (div_done) begin
					state_n = S_MUL_T;
				end
			end
			S_MUL_T:    state_n = S_MUL_R;
			S_MUL_R:    state_n = S_UPDATE;
			S_UPDATE:   state_n = S_CLOSE;
			S_FIN_PREP: state_n = S_EMIT_BYTE;
			S_FIN_BYTE: if (eack) state_n = S_FIN_C2;
			S_FIN_C2:   if (eack) state_n = S_FIN_C1;
			S_FIN_C1:   if (eack) state_n = S_FIN_C0;
			S_FIN_C0:   if (eack) state_n = S_CLOSE;
			S_CLOSE:    if (eack) state_n = S_IDLE;
			default:    state_n = S_IDLE;
		endcase
	end

	// outputs to the divider and the output stage
	always_comb begin
		div_start       = (state_q == S_CHECK) && !need_renorm && (op_q == OP_CODE_TOTAL);
		ereq.push       = 1'b0;
		ereq.close      = 1'b0;
		eres.out_byte   = 8'h00;
		eres.repeat_res = CODE_W'(1);
		eres.byte_total = bt_q;
		case (state_q)
			S_EMIT_BYTE: begin
				ereq.push     = 1'b1;
				eres.out_byte = carry_q ? (delayed_q + 8'd1) : delayed_q;
			end
			S_EMIT_RUN: begin
				ereq.push       = 1'b1;
				eres.out_byte   = carry_q ? 8'h00 : 8'hFF;
				eres.repeat_res = pending_q;
			end
			S_FIN_BYTE: begin
				ereq.push     = 1'b1;
				eres.out_byte = fin_byte_q;
			end
			S_FIN_C2: begin
				ereq.push     = 1'b1;
				eres.out_byte = bt_q[23:16];
			end
			S_FIN_C1: begin
				ereq.push     = 1'b1;
				eres.out_byte = bt_q[15:8];
			end
			S_FIN_C0: begin
				ereq.push     = 1'b1;
				eres.out_byte = bt_q[7:0];
			end
			S_CLOSE: begin
				ereq.close = 1'b1;
			end
			default: begin
				ereq.push = 1'b0;
			end
		endcase
	end

	// state register and coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			header_q  <= '0;
			start_q   <= '0;
			low_q     <= '0;
			range_q   <= TOP_VAL;
			delayed_q <= '0;
			pending_q <= '0;
			counter_q <= '0;
		end else begin
			state_q <= state_n;
			// configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HEADER_BYTE: header_q <= cfg_data[7:0];
					CFG_START_COUNT: start_q  <= cfg_data;
					default:         header_q <= header_q;
				endcase
			end
			// pending byte grows when the top byte is still undecided
			if (state_q == S_CHECK && need_renorm && !(low_q < FF_LIMIT)
					&& !low_q[CODE_W-1] && pending_q != '1) begin
				pending_q <= pending_q + 1'b1;
			end
			if (flush_end) begin
				pending_q <= '0;
				if (!(op_q == OP_FINISH && !need_renorm)) begin
					delayed_q <= low_q[CODE_W-2:BYTE_POS];
				end
			end
			// shift out one byte position
			if (state_q == S_SHIFT) begin
				range_q   <= range_q << 8;
				low_q     <= (low_q << 8) & LOW_MASK;
				counter_q <= counter_q + 1'b1;
			end
			// coding update
			if (state_q == S_UPDATE) begin
				low_q   <= low_q + t_q;
				range_q <= range_new;
			end
			if (state_q == S_FIN_PREP) begin
				counter_q <= counter_q + FIN_BYTES;
			end
			// finish returns the coder to its start values
			if (state_q == S_CLOSE && eack && op_q == OP_FINISH) begin
				low_q     <= '0;
				range_q   <= TOP_VAL;
				delayed_q <= header_q;
				pending_q <= '0;
				counter_q <= {{(CODE_W-CFG_DATA_W){1'b0}}, start_q};
			end
		end
	end

	// item and work registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode_t'(opcode);
			sym_q <= sym_freq;
			cum_q <= cum_freq;
			tot_q <= total_freq;
			sh_q  <= total_shift;
			bt_q  <= (opcode_t'(opcode) == OP_FINISH) ?
				(counter_q + {{(CODE_W-2){1'b0}}, nsteps} + FIN_BYTES) : '0;
		end
		if (state_q == S_CHECK && need_renorm) begin
			carry_q <= !(low_q < FF_LIMIT);
		end
		if (state_q == S_CHECK && !need_renorm && op_q == OP_CODE_SHIFT) begin
			r_q <= range_q >> sh_q;
		end
		if (state_q == S_DIV_WAIT && div_done) begin
			r_q <= div_quo;
		end
		if (state_q == S_MUL_T) begin
			t_q <= mul_p;
		end
		if (state_q == S_MUL_R) begin
			rs_q <= mul_p;
		end
		if (state_q == S_FIN_PREP) begin
			carry_q    <= (fin_t > 10'd255);
			fin_byte_q <= fin_t[7:0];
		end
	end

	rce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (range_q),
		.divisor  (tot_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	rce_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (ereq),
		.res        (eres),
		.ack        (eack),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.repeat_res (repeat_res),
		.last       (last),
		.byte_total (byte_total)
	);

endmodule
